[rtl/pwsm_pkg.sv]
package pwsm_pkg;

  localparam int NUM_SENSORS = 8;
  localparam int PROX_W      = 12;
  localparam int BASE_W      = 16;
  localparam int OUT_W       = 11;
  localparam int CFG_W       = 15;
  localparam int CFG_IDX_W   = 3;

  // weighted sums span -696150 .. 409500
  localparam int ACC_W  = 21;
  localparam int ABS_W  = ACC_W - 1;
  localparam int SUM_W  = 15;
  localparam int QUOT_W = 12;

  // divide by 350: q0 = (a * DIV_RECIP) >> DIV_SHIFT, then one correction step
  localparam int             AVOID_DIVISOR = 350;
  localparam int             DIV_SHIFT     = 29;
  localparam int             RECIP_W       = 21;
  localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'((64'd1 << DIV_SHIFT) / AVOID_DIVISOR);
  localparam int             MUL_W         = ABS_W + RECIP_W;
  localparam int             Q0_W          = 11;

  // base reduction: base * peak / 8192
  localparam int RED_SHIFT = 13;
  localparam int RPROD_W   = BASE_W + PROX_W + 1;

  localparam int ADJ_W   = BASE_W + 1;
  localparam int TOTAL_W = ADJ_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CROWD_THRESHOLD = 3'd0,
    REG_LEFT_BIAS       = 3'd1,
    REG_RIGHT_BIAS      = 3'd2,
    REG_SPEED_LIMIT     = 3'd3
  } cfg_reg_t;

  localparam logic [14:0]       CROWD_RESET       = 15'd2800;
  localparam logic signed [7:0] LEFT_BIAS_RESET   = 8'sd66;
  localparam logic signed [7:0] RIGHT_BIAS_RESET  = 8'sd72;
  localparam logic [9:0]        SPEED_LIMIT_RESET = 10'd800;

  typedef logic signed [7:0] coef_t;
  typedef coef_t coef_row_t [NUM_SENSORS];

  localparam coef_row_t COEF_RIGHT = '{
    8'sd17, 8'sd29, 8'sd34, 8'sd10, 8'sd8, -8'sd38, -8'sd56, -8'sd76
  };
  localparam coef_row_t COEF_LEFT = '{
    -8'sd72, -8'sd58, -8'sd36, 8'sd8, 8'sd10, 8'sd36, 8'sd28, 8'sd18
  };

  typedef struct packed {
    logic s2;
    logic s3;
  } div_en_t;

endpackage

[rtl/pwsm_div350.sv]
// Two-stage signed divide by 350, truncating toward zero.
module pwsm_div350 (
  input  logic                                clk,
  input  pwsm_pkg::div_en_t                   en,
  input  logic signed [pwsm_pkg::ACC_W-1:0]   acc,
  output logic signed [pwsm_pkg::QUOT_W-1:0]  quot
);
  import pwsm_pkg::*;

  logic [ACC_W-1:0] acc_mag;
  logic [ABS_W-1:0] mag_next;
  logic [MUL_W-1:0] mul_next;

  logic             neg;
  logic [ABS_W-1:0] mag;
  logic [MUL_W-1:0] mul;

  logic [Q0_W-1:0]   q0;
  logic [ABS_W-1:0]  rem;
  logic [Q0_W:0]     q;
  logic [QUOT_W-1:0] q_ext;

  always_comb begin
    acc_mag  = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    mag_next = acc_mag[ABS_W-1:0];
    mul_next = MUL_W'({{RECIP_W{1'b0}}, mag_next} * {{ABS_W{1'b0}}, DIV_RECIP});
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      neg <= acc[ACC_W-1];
      mag <= mag_next;
      mul <= mul_next;
    end
  end

  // estimate is exact or one low
  always_comb begin
    q0    = mul[DIV_SHIFT+Q0_W-1:DIV_SHIFT];
    rem   = mag - ABS_W'(q0 * ABS_W'(AVOID_DIVISOR));
    q     = (Q0_W+1)'(q0) + ((rem >= ABS_W'(AVOID_DIVISOR)) ? (Q0_W+1)'(1) : (Q0_W+1)'(0));
    q_ext = QUOT_W'(q);
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      quot <= neg ? $signed(-q_ext) : $signed(q_ext);
    end
  end

endmodule

[rtl/proximity_wheel_speed_mixer_unit.sv]
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_stall   prox0..prox7, base_left, base_right
// out       output     out_valid / out_stall left_speed, right_speed
// cfg       input      cfg_we                cfg_index, cfg_data
//
// Four register stages: mix sums, multiplies, divide correction, clamp.
// One item per cycle while out_stall is low; items move on through the stages in order.
// Synchronous reset empties the pipeline and loads register defaults.
// Each stage holds while the one after it is full and stalled, so bubbles
// close up; in_stall rises only when all four stages hold items.
module proximity_wheel_speed_mixer_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [pwsm_pkg::PROX_W-1:0]         prox0,
  input  logic [pwsm_pkg::PROX_W-1:0]         prox1,
  input  logic [pwsm_pkg::PROX_W-1:0]         prox2,
  input  logic [pwsm_pkg::PROX_W-1:0]         prox3,
  input  logic [pwsm_pkg::PROX_W-1:0]         prox4,
  input  logic [pwsm_pkg::PROX_W-1:0]         prox5,
  input  logic [pwsm_pkg::PROX_W-1:0]         prox6,
  input  logic [pwsm_pkg::PROX_W-1:0]         prox7,
  input  logic signed [pwsm_pkg::BASE_W-1:0]  base_left,
  input  logic signed [pwsm_pkg::BASE_W-1:0]  base_right,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [pwsm_pkg::OUT_W-1:0]   left_speed,
  output logic signed [pwsm_pkg::OUT_W-1:0]   right_speed,
  input  logic                                cfg_we,
  input  logic [pwsm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pwsm_pkg::CFG_W-1:0]          cfg_data
);
  import pwsm_pkg::*;

  // configuration
  logic [14:0]       crowd_threshold;
  logic signed [7:0] left_bias;
  logic signed [7:0] right_bias;
  logic [9:0]        speed_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      crowd_threshold <= CROWD_RESET;
      left_bias       <= LEFT_BIAS_RESET;
      right_bias      <= RIGHT_BIAS_RESET;
      speed_limit     <= SPEED_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CROWD_THRESHOLD: crowd_threshold <= cfg_data[14:0];
        REG_LEFT_BIAS:       left_bias       <= $signed(cfg_data[7:0]);
        REG_RIGHT_BIAS:      right_bias      <= $signed(cfg_data[7:0]);
        REG_SPEED_LIMIT:     speed_limit     <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // stage enables
  logic    v1, v2, v3;
  logic    en1, en2, en3, en4;
  div_en_t div_en;

  always_comb begin
    en4      = !out_valid || !out_stall;
    en3      = !v3 || en4;
    en2      = !v2 || en3;
    en1      = !v1 || en2;
    in_stall = !en1;
    div_en   = '{s2: en2, s3: en3};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) out_valid <= v3;
    end
  end

  // stage 1: weighted sums, reading sum and peak
  logic [PROX_W-1:0]       prox_a [NUM_SENSORS];
  logic signed [ACC_W-1:0] acc_l_next, acc_r_next, px;
  logic [SUM_W-1:0]        sum_next;
  logic [PROX_W-1:0]       peak_next;
  logic [PROX_W-1:0]       peak4 [NUM_SENSORS/2];
  logic [PROX_W-1:0]       peak2 [NUM_SENSORS/4];

  assign prox_a = '{prox0, prox1, prox2, prox3, prox4, prox5, prox6, prox7};

  always_comb begin
    acc_l_next = '0;
    acc_r_next = '0;
    sum_next   = '0;
    px         = '0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      px         = ACC_W'($signed({1'b0, prox_a[i]}));
      acc_r_next = acc_r_next + ACC_W'(COEF_RIGHT[i]) * px;
      acc_l_next = acc_l_next + ACC_W'(COEF_LEFT[i]) * px;
      sum_next   = sum_next + SUM_W'(prox_a[i]);
    end
    // peak through a three-level compare tree
    for (int i = 0; i < NUM_SENSORS/2; i++) begin
      peak4[i] = (prox_a[2*i] > prox_a[2*i+1]) ? prox_a[2*i] : prox_a[2*i+1];
    end
    for (int i = 0; i < NUM_SENSORS/4; i++) begin
      peak2[i] = (peak4[2*i] > peak4[2*i+1]) ? peak4[2*i] : peak4[2*i+1];
    end
    peak_next = (peak2[0] > peak2[1]) ? peak2[0] : peak2[1];
  end

  logic signed [ACC_W-1:0]  acc_l1, acc_r1;
  logic [SUM_W-1:0]         sum1;
  logic [PROX_W-1:0]        peak1;
  logic signed [BASE_W-1:0] bl1, br1;

  always_ff @(posedge clk) begin
    if (en1) begin
      acc_l1 <= acc_l_next;
      acc_r1 <= acc_r_next;
      sum1   <= sum_next;
      peak1  <= peak_next;
      bl1    <= base_left;
      br1    <= base_right;
    end
  end

  // stage 2: base times peak, crowd test (divide runs in its own unit)
  logic signed [RPROD_W-1:0] peak_s;
  logic signed [RPROD_W-1:0] rprod_l2, rprod_r2;
  logic signed [BASE_W-1:0]  bl2, br2;
  logic                      crowd2;

  assign peak_s = RPROD_W'($signed({1'b0, peak1}));

  always_ff @(posedge clk) begin
    if (en2) begin
      rprod_l2 <= RPROD_W'(bl1) * peak_s;
      rprod_r2 <= RPROD_W'(br1) * peak_s;
      bl2      <= bl1;
      br2      <= br1;
      crowd2   <= sum1 > SUM_W'(crowd_threshold);
    end
  end

  // stage 3: truncating shift of the reduction, apply it
  logic signed [RPROD_W-1:0] red_l, red_r;
  logic signed [ADJ_W-1:0]   bl3, br3;
  logic signed [QUOT_W-1:0]  avoid_l3, avoid_r3;

  always_comb begin
    red_l = (rprod_l2 + (rprod_l2[RPROD_W-1] ? RPROD_W'((1 << RED_SHIFT) - 1) : RPROD_W'(0)))
            >>> RED_SHIFT;
    red_r = (rprod_r2 + (rprod_r2[RPROD_W-1] ? RPROD_W'((1 << RED_SHIFT) - 1) : RPROD_W'(0)))
            >>> RED_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      bl3 <= crowd2 ? ADJ_W'(bl2) - ADJ_W'(red_l) : ADJ_W'(bl2);
      br3 <= crowd2 ? ADJ_W'(br2) - ADJ_W'(red_r) : ADJ_W'(br2);
    end
  end

  pwsm_div350 u_div_left (
    .clk  (clk),
    .en   (div_en),
    .acc  (acc_l1),
    .quot (avoid_l3)
  );

  pwsm_div350 u_div_right (
    .clk  (clk),
    .en   (div_en),
    .acc  (acc_r1),
    .quot (avoid_r3)
  );

  // stage 4: add avoidance term and bias, clamp
  logic signed [TOTAL_W-1:0] tot_l, tot_r, lim_pos, lim_neg;
  logic signed [TOTAL_W-1:0] clamp_l, clamp_r;

  always_comb begin
    lim_pos = TOTAL_W'($signed({1'b0, speed_limit}));
    lim_neg = -lim_pos;
    tot_l   = TOTAL_W'(bl3) + TOTAL_W'(avoid_l3) + TOTAL_W'(left_bias);
    tot_r   = TOTAL_W'(br3) + TOTAL_W'(avoid_r3) + TOTAL_W'(right_bias);
    clamp_l = (tot_l > lim_pos) ? lim_pos : ((tot_l < lim_neg) ? lim_neg : tot_l);
    clamp_r = (tot_r > lim_pos) ? lim_pos : ((tot_r < lim_neg) ? lim_neg : tot_r);
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      left_speed  <= OUT_W'(clamp_l);
      right_speed <= OUT_W'(clamp_r);
    end
  end

endmodule

[rtl/pwsm_checker.sv]
module pwsm_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [pwsm_pkg::OUT_W-1:0]   left_speed,
  input logic signed [pwsm_pkg::OUT_W-1:0]   right_speed
);

  // empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // input backs up only behind a valid output that is stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while pipeline can move");

  // an accepted item reaches the output when the output keeps draining
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("accepted item did not reach the output");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(left_speed) && $stable(right_speed)))
    else $error("stalled output item changed");

endmodule

bind proximity_wheel_speed_mixer_unit pwsm_checker u_pwsm_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .left_speed  (left_speed),
  .right_speed (right_speed)
);
